@@ rtl/fdm_pkg.sv @@
// ----------------------------------------------------------------------------
// Frequency and duty meter package
// Shared types and constants for the frequency and duty-cycle meter.
// ----------------------------------------------------------------------------
`default_nettype none

package fdm_pkg;

  // Field widths of the stream payloads.
  localparam int TICKS_BITS     = 16;
  localparam int FREQ_BITS      = 26;
  localparam int DUTY_BITS      = 14;
  localparam int CLOCK_HZ_BITS  = 27;
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 2 * TICKS_BITS + FREQ_BITS + DUTY_BITS;

  // Reset rate of the timer and the duty scale (hundredths of a percent).
  localparam logic [CLOCK_HZ_BITS-1:0] CLOCK_HZ_RESET = 27'd1000000;
  localparam logic [DUTY_BITS-1:0]     DUTY_SCALE     = 14'd10000;

  // Capture phase of the edge tracker.
  typedef enum logic [1:0] {
    PH_RISE1 = 2'd0,
    PH_FALL  = 2'd1,
    PH_RISE2 = 2'd2
  } phase_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_SAMPLE    = 3'd0,
    S_FREQ      = 3'd1,
    S_FREQ_WAIT = 3'd2,
    S_DUTY      = 3'd3,
    S_DUTY_WAIT = 3'd4,
    S_LOAD      = 3'd5
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sample;     // input transaction this cycle
    logic start_div;  // launch the divider
    logic sel_duty;   // divider operands: 0 frequency, 1 duty
    logic save_freq;  // keep the divider quotient as frequency
    logic save_duty;  // keep the divider quotient as duty
    logic load_out;   // move the finished result into the output register
  } fdm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic measure_ok; // current sample completes an ordered measurement
    logic div_done;   // divider quotient is ready
    logic out_free;   // output register can take a result this cycle
  } fdm_status_t;

endpackage

`default_nettype wire

@@ rtl/fdm_div.sv @@
// ----------------------------------------------------------------------------
// Frequency and duty meter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdm_div #(
  parameter int DVD_BITS = 30,
  parameter int DVS_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [DVD_BITS-1:0] dividend,
  input  wire logic [DVS_BITS-1:0] divisor,
  output logic                     busy,
  output logic                     done,
  output logic [DVD_BITS-1:0]      quotient
);

  localparam int CNT_BITS = $clog2(DVD_BITS + 1);

  logic [CNT_BITS-1:0] cnt;
  logic [DVS_BITS-1:0] rem;
  logic [DVS_BITS-1:0] dvs;
  logic [DVD_BITS-1:0] dq;
  logic [DVS_BITS:0]   partial;
  logic                ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    partial = {rem, dq[DVD_BITS-1]};
    ge      = partial >= {1'b0, dvs};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_BITS'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DVD_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Shared dividend and quotient register, plus the partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[DVD_BITS-2:0], ge};
      rem <= ge ? DVS_BITS'(partial - {1'b0, dvs}) : partial[DVS_BITS-1:0];
    end
  end

  assign quotient = dq;

endmodule

`default_nettype wire

@@ rtl/fdm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Frequency and duty meter controller
// Sequences sampling, the two divisions and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module fdm_ctrl
  import fdm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire fdm_status_t status,
  output fdm_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SAMPLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      S_SAMPLE: begin
        s_tready   = 1'b1;
        cmd.sample = s_tvalid;
        if (s_tvalid && status.measure_ok) begin
          state_next = S_FREQ;
        end
      end
      S_FREQ: begin
        cmd.start_div = 1'b1;
        state_next    = S_FREQ_WAIT;
      end
      S_FREQ_WAIT: begin
        if (status.div_done) begin
          cmd.save_freq = 1'b1;
          state_next    = S_DUTY;
        end
      end
      S_DUTY: begin
        cmd.start_div = 1'b1;
        cmd.sel_duty  = 1'b1;
        state_next    = S_DUTY_WAIT;
      end
      S_DUTY_WAIT: begin
        cmd.sel_duty = 1'b1;
        if (status.div_done) begin
          cmd.save_duty = 1'b1;
          state_next    = S_LOAD;
        end
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_SAMPLE;
        end
      end
      default: begin
        state_next = S_SAMPLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/fdm_datapath.sv @@
// ----------------------------------------------------------------------------
// Frequency and duty meter datapath
// Edge capture, tick counter, duty product, divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fdm_datapath
  import fdm_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      level,
  input  wire logic                      cfg_valid,
  input  wire logic [CLOCK_HZ_BITS-1:0]  cfg_data,
  input  wire logic                      m_tready,
  output logic                           m_tvalid,
  output logic [OUT_TDATA_BITS-1:0]      m_tdata,
  input  wire fdm_cmd_t                  cmd,
  output fdm_status_t                    status
);

  localparam int PROD_BITS = COUNT_BITS + DUTY_BITS;
  localparam int DVD_BITS  = (PROD_BITS > CLOCK_HZ_BITS) ? PROD_BITS : CLOCK_HZ_BITS;

  logic [CLOCK_HZ_BITS-1:0] clock_hz;
  logic                     prev_level;
  phase_t                   phase;
  logic [COUNT_BITS-1:0]    tick_cnt;
  logic [COUNT_BITS-1:0]    first_rise;
  logic [COUNT_BITS-1:0]    fall_time;
  logic [COUNT_BITS-1:0]    high;
  logic [COUNT_BITS-1:0]    period;
  logic [PROD_BITS-1:0]     prod;
  logic [FREQ_BITS-1:0]     freq;
  logic [DUTY_BITS-1:0]     duty;
  logic                     out_full;
  logic                     rise;
  logic                     fall;
  logic                     ordered;
  logic                     restart;
  logic [DVD_BITS-1:0]      dividend;
  logic [DVD_BITS-1:0]      quotient;
  logic                     div_busy;
  logic                     div_done;

  // Clock rate register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_HZ_RESET;
    end else if (cfg_valid) begin
      clock_hz <= cfg_data;
    end
  end

  // Edge detection and the ordering check of the three captures.
  always_comb begin
    rise       = level && !prev_level;
    fall       = !level && prev_level;
    ordered    = (first_rise < fall_time) && (fall_time < tick_cnt);
    restart    = (phase == PH_RISE2) && rise;
    status.measure_ok = restart && ordered;
    status.div_done   = div_done;
    status.out_free   = !out_full || m_tready;
  end

  // Capture phase, level history and tick counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b0;
      phase      <= PH_RISE1;
      tick_cnt   <= '0;
    end else if (cmd.sample) begin
      prev_level <= level;
      tick_cnt   <= restart ? '0 : tick_cnt + COUNT_BITS'(1);
      case (phase)
        PH_RISE1: begin
          if (rise) begin
            phase <= PH_FALL;
          end
        end
        PH_FALL: begin
          if (fall) begin
            phase <= PH_RISE2;
          end
        end
        PH_RISE2: begin
          if (rise) begin
            phase <= PH_RISE1;
          end
        end
        default: begin
          phase <= PH_RISE1;
        end
      endcase
    end
  end

  // Capture times, high time and period.
  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      if (phase == PH_RISE1 && rise) begin
        first_rise <= tick_cnt;
      end
      if (phase == PH_FALL && fall) begin
        fall_time <= tick_cnt;
        high      <= tick_cnt - first_rise;
      end
      if (restart) begin
        period <= tick_cnt - first_rise;
      end
    end
  end

  // Duty dividend: high time scaled to hundredths of a percent.
  always_ff @(posedge clk) begin
    prod <= PROD_BITS'(high) * PROD_BITS'(DUTY_SCALE);
  end

  // Shared divider for both quotients.
  assign dividend = cmd.sel_duty ? DVD_BITS'(prod) : DVD_BITS'(clock_hz);

  fdm_div #(
    .DVD_BITS (DVD_BITS),
    .DVS_BITS (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (dividend),
    .divisor  (period),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // Quotient holding registers.
  always_ff @(posedge clk) begin
    if (cmd.save_freq) begin
      freq <= quotient[FREQ_BITS-1:0];
    end
    if (cmd.save_duty) begin
      duty <= quotient[DUTY_BITS-1:0];
    end
  end

  // Output register: period, high, frequency, duty from the lowest bit up.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.load_out) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {duty, freq, TICKS_BITS'(high), TICKS_BITS'(period)};
    end
  end

  assign m_tvalid = out_full;

  // A completed measurement always restarts the tick counter.
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.sample && restart) |=> (tick_cnt == '0))
    else $error("tick counter not cleared after a completing edge");

  // The duty result is below one hundred percent.
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (duty < DUTY_SCALE))
    else $error("duty result out of range");

  // The divider is never relaunched while it iterates.
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start_div |-> !div_busy)
    else $error("divider started while busy");

  // The divider signals completion for a single cycle.
  a_div_done_pulse: assert property (@(posedge clk) disable iff (rst)
    div_done |=> !div_done)
    else $error("divider done held for more than one cycle");

endmodule

`default_nettype wire

@@ rtl/frequency_duty_meter.sv @@
// ----------------------------------------------------------------------------
// Frequency and duty meter
// Measures period, high time, frequency and duty cycle of a sampled signal.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one level sample per transaction (s_tdata[0]). Each accepted
//   sample is one timer tick. When a sample closes an ordered rise, fall,
//   rise sequence, one result goes out on m_*: period, high time, frequency
//   (clock_hz / period) and duty in hundredths of a percent, both truncated.
//   Measurements whose captures wrapped the counter give no result.
//   cfg_* writes clock_hz; write it only while the block is idle.
// Throughput:
//   A sample is taken every cycle while no result is being computed or is
//   waiting to load. After a completing sample, input stalls while one
//   restoring divider produces the two quotients, one bit per cycle. The
//   result is offered at the clock edge that ends this stall.
// Reset and stalls:
//   Reset clears the counter and edge tracker and sets clock_hz to 1000000.
//   The result waits in an output register; sampling continues while it
//   waits, and only the next result stalls until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module frequency_duty_meter
  import fdm_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Sample stream. s_tdata: level [0], zero fill [7:1].
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,
  // Result stream. m_tdata: period_ticks [15:0], high_ticks [31:16],
  // frequency_hz [57:32], duty_hundredths [71:58].
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0]      m_tdata,
  // Configuration write: clock_hz.
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CLOCK_HZ_BITS-1:0]  cfg_data
);

  fdm_cmd_t    cmd;
  fdm_status_t status;

  // The clock rate register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  fdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fdm_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .level     (s_tdata[0]),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Frequency and duty meter testbench
// Feeds level samples through the sample stream and checks every result
// against a known table value or a model of the capture logic. A short
// table covers extremes and named corner cases. Random waveforms follow,
// spread over several clock_hz settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fdm_pkg::*;

  // Cycles with no transaction anywhere before the run is declared hung.
  // The longest legal quiet stretch is the forced receiver hold plus one
  // divider pass, well under this.
  localparam int unsigned QUIET_LIMIT = 5000;
  // Settling time after the last expected result.
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 450;

  typedef struct packed {
    logic [TICKS_BITS-1:0] period;
    logic [TICKS_BITS-1:0] high;
    logic [FREQ_BITS-1:0]  freq;
    logic [DUTY_BITS-1:0]  duty;
  } meas_t;

  typedef enum logic {ROW_LEVEL, ROW_CLOCK_HZ} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    int unsigned value;   // level for ROW_LEVEL, clock_hz for ROW_CLOCK_HZ
    int unsigned len;     // samples held at this level
    bit          typed;   // last sample of the row closes a known measurement
    meas_t       known;
  } row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [IN_TDATA_BITS-1:0]     s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0]    m_tdata;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CLOCK_HZ_BITS-1:0]     cfg_data = '0;

  frequency_duty_meter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Model of the capture logic, kept in step with accepted samples.
  logic                     mdl_prev;
  phase_t                   mdl_phase;
  logic [TICKS_BITS-1:0]    mdl_count;
  logic [TICKS_BITS-1:0]    mdl_rise;
  logic [TICKS_BITS-1:0]    mdl_fall;
  logic [CLOCK_HZ_BITS-1:0] mdl_clock_hz;

  meas_t       pending_meas[$];
  row_t        dir_rows[$];
  int unsigned error_count;
  int unsigned result_no;
  int unsigned rand_items;
  bit          no_idle;
  bit          pressure_req;
  bit          pressure_done;
  int unsigned quiet_cycles;
  int unsigned rx_stall_left;
  int unsigned rx_hold_left;
  int unsigned rx_gap;
  meas_t       rx_got;
  meas_t       rx_want;

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got)
      report_error($sformatf("result %0d %s: expected %0d, got %0d",
                             result_no, name, want, got));
  endtask

  // Mostly back to back, sometimes a short gap, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 6);
    if (r < 97) return $urandom_range(7, 60);
    return $urandom_range(61, 400);
  endfunction

  // Advances the model by one sample; returns 1 when a measurement completes.
  function automatic bit meter_sample(input logic lvl, output meas_t m);
    bit                    rise;
    bit                    fall;
    bit                    done;
    bit                    restart;
    logic [TICKS_BITS-1:0] now;
    longint unsigned       per;
    longint unsigned       hi;
    rise    = lvl && !mdl_prev;
    fall    = !lvl && mdl_prev;
    now     = mdl_count;
    done    = 1'b0;
    restart = 1'b0;
    m       = '0;
    case (mdl_phase)
      PH_RISE1: begin
        if (rise) begin
          mdl_rise  = now;
          mdl_phase = PH_FALL;
        end
      end
      PH_FALL: begin
        if (fall) begin
          mdl_fall  = now;
          mdl_phase = PH_RISE2;
        end
      end
      default: begin
        if (rise) begin
          // Captures out of order mean the counter wrapped: drop quietly.
          if (mdl_rise < mdl_fall && mdl_fall < now) begin
            per      = now - mdl_rise;
            hi       = mdl_fall - mdl_rise;
            m.period = per[TICKS_BITS-1:0];
            m.high   = hi[TICKS_BITS-1:0];
            m.freq   = FREQ_BITS'(longint'(mdl_clock_hz) / per);
            m.duty   = DUTY_BITS'((hi * DUTY_SCALE) / per);
            done     = 1'b1;
          end
          restart   = 1'b1;
          mdl_phase = PH_RISE1;
        end
      end
    endcase
    mdl_count = restart ? '0 : now + 1'b1;
    mdl_prev  = lvl;
    return done;
  endfunction

  // Offers one sample and waits for its transaction.
  task automatic send_level(input logic lvl, input bit allow_gap,
                            output bit produced, output meas_t m);
    int unsigned gap;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_BITS-1){1'b0}}, lvl};
    do @(posedge clk); while (!s_tready);
    produced = meter_sample(lvl, m);
  endtask

  // Random part: a run of samples at one level, expectations from the model.
  task automatic send_run(input logic lvl, input int unsigned n);
    bit    produced;
    meas_t m;
    for (int unsigned k = 0; k < n; k++) begin
      send_level(lvl, 1'b1, produced, m);
      rand_items++;
      if (produced) begin
        pending_meas.push_back(m);
      end
    end
  endtask

  // Writes clock_hz once the block has drained and gone quiet.
  task automatic write_clock_hz(input int unsigned value);
    s_tvalid <= 1'b0;
    while (pending_meas.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[CLOCK_HZ_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    mdl_clock_hz = value[CLOCK_HZ_BITS-1:0];
  endtask

  task automatic add_row(input row_kind_t kind, input int unsigned value,
                         input int unsigned len, input bit typed,
                         input int unsigned per, input int unsigned hi,
                         input int unsigned freq, input int unsigned duty);
    row_t r;
    r.kind        = kind;
    r.value       = value;
    r.len         = len;
    r.typed       = typed;
    r.known.period = per[TICKS_BITS-1:0];
    r.known.high   = hi[TICKS_BITS-1:0];
    r.known.freq   = freq[FREQ_BITS-1:0];
    r.known.duty   = duty[DUTY_BITS-1:0];
    dir_rows.push_back(r);
  endtask

  // One rise, fall, rise waveform with random widths, or single-sample runs when tight.
  task automatic send_waveform(input bit tight);
    send_run(1'b0, tight ? 1 : pick_len());
    send_run(1'b1, tight ? 1 : pick_len());
    send_run(1'b0, tight ? 1 : pick_len());
    send_run(1'b1, 1);
  endtask

  // Receiver: random stalls, plus one long forced hold on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready      <= 1'b0;
      rx_stall_left <= 0;
      rx_hold_left  <= 0;
      pressure_done <= 1'b0;
    end else if (rx_hold_left > 0) begin
      m_tready     <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (pressure_req && !pressure_done) begin
      m_tready      <= 1'b0;
      rx_hold_left  <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else if (rx_stall_left > 0) begin
      m_tready      <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      rx_gap = pick_gap();
      if (rx_gap > 0) begin
        m_tready      <= 1'b0;
        rx_stall_left <= rx_gap - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result checker: each result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      rx_got.period = m_tdata[15:0];
      rx_got.high   = m_tdata[31:16];
      rx_got.freq   = m_tdata[57:32];
      rx_got.duty   = m_tdata[71:58];
      if (pending_meas.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", result_no));
      end else begin
        rx_want = pending_meas.pop_front();
        check_field("period_ticks", rx_want.period, rx_got.period);
        check_field("high_ticks", rx_want.high, rx_got.high);
        check_field("frequency_hz", rx_want.freq, rx_got.freq);
        check_field("duty_hundredths", rx_want.duty, rx_got.duty);
      end
      result_no++;
    end
  end

  // Watchdog: ends a run in which nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit          produced;
    meas_t       m;
    int unsigned phase_no;
    int unsigned phase_end;

    error_count  = 0;
    result_no    = 0;
    rand_items   = 0;
    no_idle      = 1'b0;
    pressure_req = 1'b0;
    mdl_prev     = 1'b0;
    mdl_phase    = PH_RISE1;
    mdl_count    = '0;
    mdl_rise     = '0;
    mdl_fall     = '0;
    mdl_clock_hz = CLOCK_HZ_RESET;

    // Directed table. Rows with a known result close a measurement.
    // High level on the very first sample is a rise at tick 0; this gives
    // the longest period, at the reset clock_hz.
    add_row(ROW_LEVEL, 1, 1, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 0, 65534, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 1, 1, 1, 65535, 1, 15, 0);
    // Shortest period. The completing rise is not reused as a first rise.
    add_row(ROW_LEVEL, 0, 1, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 1, 1, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 0, 1, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 1, 1, 1, 2, 1, 500000, 5000);
    // Fastest clock: highest frequency, then highest duty.
    add_row(ROW_CLOCK_HZ, 100000000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 0, 1, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 1, 1, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 0, 1, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 1, 1, 1, 2, 1, 50000000, 5000);
    add_row(ROW_LEVEL, 0, 1, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 1, 40000, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 0, 1, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 1, 1, 1, 40001, 40000, 2499, 9999);
    // A zero clock rate gives zero frequency.
    add_row(ROW_CLOCK_HZ, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 0, 3, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 1, 5, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 0, 2, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 1, 1, 1, 7, 5, 0, 7142);
    // First rise on the last tick before the counter wraps: no result.
    add_row(ROW_LEVEL, 0, 65535, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 1, 2, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 0, 1, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 1, 1, 0, 0, 0, 0, 0);
    // The block must have restarted cleanly after the dropped measurement.
    add_row(ROW_CLOCK_HZ, 1, 0, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 0, 1, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 1, 3, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 0, 4, 0, 0, 0, 0, 0);
    add_row(ROW_LEVEL, 1, 1, 0, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CLOCK_HZ) begin
        write_clock_hz(dir_rows[i].value);
      end else begin
        for (int unsigned k = 0; k < dir_rows[i].len; k++) begin
          // Long runs go back to back to keep the run short.
          send_level(dir_rows[i].value[0], dir_rows[i].len <= 100, produced, m);
          if (dir_rows[i].typed && k == dir_rows[i].len - 1)
            pending_meas.push_back(dir_rows[i].known);
          else if (produced)
            pending_meas.push_back(m);
        end
      end
    end

    // Random phases, each at its own clock_hz. Phase 1 never idles, phase 2
    // runs short waveforms against a long receiver hold.
    phase_no = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case (phase_no % 6)
        0:       write_clock_hz(1);
        1:       write_clock_hz(100000000);
        2:       write_clock_hz($urandom_range(1000, 100000000));
        3:       write_clock_hz($urandom_range(1, 1000));
        default: write_clock_hz($urandom_range(0, 100000000));
      endcase
      no_idle      = (phase_no == 1);
      pressure_req = (phase_no == 2);
      phase_end    = rand_items + 90;
      while (rand_items < phase_end) begin
        if (phase_no == 2) begin
          send_waveform(1'b1);
        end else if ($urandom_range(0, 9) < 8) begin
          send_waveform(1'b0);
        end else begin
          // Noise: a burst of random levels.
          for (int unsigned k = $urandom_range(1, 8); k > 0; k--)
            send_run(1'($urandom_range(0, 1)), 1);
        end
      end
      no_idle      = 1'b0;
      pressure_req = 1'b0;
      phase_no++;
    end

    s_tvalid <= 1'b0;
    while (pending_meas.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/fdm_pkg.sv
rtl/fdm_div.sv
rtl/fdm_ctrl.sv
rtl/fdm_datapath.sv
rtl/frequency_duty_meter.sv
tb/testbench.sv
